### sv/utf8x_pkg.sv
// Shared types, constants and helper functions of the extended UTF-8 codec.
package utf8x_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic FUNC_DEC = 1'b0;
	localparam logic FUNC_ENC = 1'b1;
	localparam logic KIND_DEC = 1'b0;
	localparam logic KIND_ENC = 1'b1;

	localparam logic [7:0] LEAD_7BYTE = 8'hFE;
	localparam logic [7:0] CONT_MARK = 8'h80;
	localparam logic [5:0] CONT_MASK = 6'h3F;

	localparam logic [31:0] ENC_MAX1 = 32'h0000007F;
	localparam logic [31:0] ENC_MAX2 = 32'h000007FF;
	localparam logic [31:0] ENC_MAX3 = 32'h0000FFFF;
	localparam logic [31:0] ENC_MAX4 = 32'h001FFFFF;
	localparam logic [31:0] ENC_MAX5 = 32'h03FFFFFF;
	localparam logic [31:0] ENC_MAX6 = 32'h7FFFFFFF;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic [2:0]  len;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} head_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] n;
		if (b < 8'h80) n = 3'd1;
		else if (b < 8'hC0) n = 3'd7;
		else if (b < 8'hE0) n = 3'd2;
		else if (b < 8'hF0) n = 3'd3;
		else if (b < 8'hF8) n = 3'd4;
		else if (b < 8'hFC) n = 3'd5;
		else if (b < 8'hFE) n = 3'd6;
		else n = 3'd7;
		return n;
	endfunction

	function automatic logic [2:0] enc_len(input logic [31:0] u);
		logic [2:0] n;
		if (u <= ENC_MAX1) n = 3'd1;
		else if (u <= ENC_MAX2) n = 3'd2;
		else if (u <= ENC_MAX3) n = 3'd3;
		else if (u <= ENC_MAX4) n = 3'd4;
		else if (u <= ENC_MAX5) n = 3'd5;
		else if (u <= ENC_MAX6) n = 3'd6;
		else n = 3'd7;
		return n;
	endfunction

	function automatic logic [7:0] lead_mask(input logic [2:0] n);
		logic [7:0] m;
		unique case (n)
			3'd1: m = 8'h7F;
			3'd2: m = 8'h1F;
			3'd3: m = 8'h0F;
			3'd4: m = 8'h07;
			3'd5: m = 8'h03;
			3'd6: m = 8'h01;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] lead_mark(input logic [2:0] n);
		logic [7:0] m;
		unique case (n)
			3'd2: m = 8'hC0;
			3'd3: m = 8'hE0;
			3'd4: m = 8'hF0;
			3'd5: m = 8'hF8;
			3'd6: m = 8'hFC;
			3'd7: m = 8'hFE;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	// Six-bit group number r of a value, counted from the least significant end.
	function automatic logic [5:0] group6(input logic [31:0] v, input logic [2:0] r);
		logic [5:0] g;
		unique case (r)
			3'd0: g = v[5:0];
			3'd1: g = v[11:6];
			3'd2: g = v[17:12];
			3'd3: g = v[23:18];
			3'd4: g = v[29:24];
			3'd5: g = {4'b0, v[31:30]};
			default: g = 6'b0;
		endcase
		return g;
	endfunction

endpackage

### sv/utf8x_if.sv
// Channel interfaces for input items and result words of the codec.
interface utf8x_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  in_byte;
	logic [31:0] in_value;

	modport source (output valid, func, in_byte, in_value, input ready);
	modport sink (input valid, func, in_byte, in_value, output ready);
endinterface

interface utf8x_result_if;
	logic        valid;
	logic        ready;
	logic        out_kind;
	logic [31:0] out_value;
	logic [7:0]  out_byte;
	logic [2:0]  seq_len;
	logic        last;

	modport source (output valid, out_kind, out_value, out_byte, seq_len, last, input ready);
	modport sink (input valid, out_kind, out_value, out_byte, seq_len, last, output ready);
endinterface

### sv/extended_utf8_codec.sv
// Extended UTF-8 codec (original 1-6 byte layout plus a 7-byte 0xFE form).
// A decode word takes one byte and a decode result appears after the last
// byte of a sequence; an encode word takes a 32-bit value and yields 1 to 7
// byte results in order, the final one flagged by last. Decoding sustains one
// byte per cycle while results are taken. An encode job holds the output until
// its last byte is out, as the back end emits one byte per cycle while results
// are taken; the job queue (QueueDepth entries) keeps accepting input meanwhile
// and then back-pressures. A word is queued, then held in the result register.
module extended_utf8_codec #(
	parameter int QueueDepth = utf8x_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	utf8x_item_if.sink     item,
	utf8x_result_if.source result
);
	import utf8x_pkg::*;

	push_t push;
	head_t head;
	logic  full;
	logic  pop;

	utf8x_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.full   (full),
		.push   (push)
	);

	utf8x_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	utf8x_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

### sv/utf8x_front.sv
// Front end: accepts items, runs the byte decoder state and sizes encode jobs.
module utf8x_front (
	input  logic               clk,
	input  logic               arst_n,
	utf8x_item_if.sink         item,
	input  logic               full,
	output utf8x_pkg::push_t   push
);
	import utf8x_pkg::*;

	logic [2:0]  dec_rem_q;
	logic [2:0]  dec_len_q;
	logic [31:0] dec_acc_q;
	logic [2:0]  llen;
	logic [2:0]  rem_nx;
	logic [2:0]  len_nx;
	logic [31:0] acc_nx;
	logic        accept;

	assign item.ready = !full;
	assign accept = item.valid && item.ready;
	assign llen = lead_len(item.in_byte);

	always_comb begin
		if (dec_rem_q == 3'd0) begin
			acc_nx = {24'b0, item.in_byte & lead_mask(llen)};
			rem_nx = llen - 3'd1;
			len_nx = llen;
		end else begin
			// Continuation bytes are taken as they come; only the low six bits count.
			acc_nx = {dec_acc_q[25:0], item.in_byte[5:0] & CONT_MASK};
			rem_nx = dec_rem_q - 3'd1;
			len_nx = dec_len_q;
		end
	end

	always_comb begin
		push.valid = accept && ((item.func == FUNC_ENC) || (rem_nx == 3'd0));
		if (item.func == FUNC_ENC) begin
			push.job.kind = KIND_ENC;
			push.job.value = item.in_value;
			push.job.len = enc_len(item.in_value);
		end else begin
			push.job.kind = KIND_DEC;
			push.job.value = acc_nx;
			push.job.len = len_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_rem_q <= 3'd0;
			dec_len_q <= 3'd0;
			dec_acc_q <= 32'd0;
		end else if (accept && item.func == FUNC_DEC) begin
			dec_rem_q <= rem_nx;
			dec_len_q <= len_nx;
			dec_acc_q <= acc_nx;
		end
	end

`ifndef SYNTHESIS
	a_ascii_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.func == FUNC_DEC && dec_rem_q == 3'd0 && !item.in_byte[7]
		|-> push.valid)
		else $error("single-byte lead did not produce a decode job");
`endif

endmodule

### sv/utf8x_queue.sv
// Short job queue between the front end and the back end.
module utf8x_queue #(
	parameter int Depth = utf8x_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  utf8x_pkg::push_t  push,
	input  logic              pop,
	output logic              full,
	output utf8x_pkg::head_t  head
);
	import utf8x_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full = (count_q == CntW'(Depth));
	assign head.valid = (count_q != '0);
	assign head.job = mem_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue occupancy beyond its depth");
`endif

endmodule

### sv/utf8x_back.sv
// Back end: turns queued jobs into result words, one encoded byte per word.
module utf8x_back (
	input  logic              clk,
	input  logic              arst_n,
	input  utf8x_pkg::head_t  head,
	output logic              pop,
	utf8x_result_if.source    result
);
	import utf8x_pkg::*;

	logic        res_valid_q;
	logic        kind_q;
	logic [31:0] value_q;
	logic [7:0]  byte_q;
	logic [2:0]  len_q;
	logic        last_q;
	logic [2:0]  k_q;
	logic        load;
	logic        is_last;
	logic [2:0]  r;
	logic [7:0]  lead;
	logic [7:0]  byte_nx;

	assign load = !res_valid_q || result.ready;
	assign is_last = (head.job.kind == KIND_DEC) || (k_q == head.job.len - 3'd1);
	assign pop = load && head.valid && is_last;
	assign r = head.job.len - 3'd1 - k_q;

	always_comb begin
		if (head.job.len == 3'd1) begin
			lead = head.job.value[7:0];
		end else if (head.job.len == 3'd7) begin
			lead = LEAD_7BYTE;
		end else begin
			lead = ({2'b0, group6(head.job.value, head.job.len - 3'd1)}
				& lead_mask(head.job.len)) | lead_mark(head.job.len);
		end
		if (head.job.kind == KIND_DEC) begin
			byte_nx = 8'd0;
		end else if (k_q == 3'd0) begin
			byte_nx = lead;
		end else begin
			byte_nx = CONT_MARK | {2'b0, group6(head.job.value, r)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			k_q <= 3'd0;
		end else if (load) begin
			res_valid_q <= head.valid;
			if (head.valid) begin
				k_q <= is_last ? 3'd0 : k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			kind_q <= head.job.kind;
			value_q <= (head.job.kind == KIND_DEC) ? head.job.value : 32'd0;
			byte_q <= byte_nx;
			len_q <= head.job.len;
			last_q <= is_last;
		end
	end

	assign result.valid = res_valid_q;
	assign result.out_kind = kind_q;
	assign result.out_value = value_q;
	assign result.out_byte = byte_q;
	assign result.seq_len = len_q;
	assign result.last = last_q;

`ifndef SYNTHESIS
	a_dec_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && kind_q == KIND_DEC |-> last_q)
		else $error("decode result without last flag");
	a_mid_job: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != 3'd0 |-> head.valid && head.job.kind == KIND_ENC)
		else $error("encode job left the queue before its last byte");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != 3'd0 |-> k_q < head.job.len)
		else $error("byte index past the sequence length");
`endif

endmodule

### sim/tb_extended_utf8_codec.sv
`timescale 1ns / 100ps
// Self-checking testbench of the extended UTF-8 codec with its own prediction of every result word.
module tb_extended_utf8_codec;
	import utf8x_pkg::*;

	localparam int ITEM_TARGET = 460;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic [7:0]  code;
		logic [2:0]  len;
		logic        last;
	} codec_word_t;

	logic clk;
	logic arst_n;

	utf8x_item_if   item_ch();
	utf8x_result_if result_ch();

	extended_utf8_codec uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	codec_word_t codec_outputs_due[$];
	codec_word_t want;
	int          fail_count;
	int          items_sent;
	bit          idle_on;
	bit          hold_ask;
	int          stall_left;
	int          hold_left;

	// Mirror of the decoder: bytes still owed, length and value of the open sequence.
	logic [2:0]  dec_left;
	logic [2:0]  dec_seq_len;
	logic [31:0] dec_acc;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// A lead byte's run of leading ones gives the length; one lone one or seven and more mean
	// the seven-byte form.
	function automatic logic [2:0] lead_byte_len(input logic [7:0] b);
		int ones;
		ones = 0;
		while (ones < 8 && b[7 - ones]) ones++;
		if (ones == 0) return 3'd1;
		if (ones == 1 || ones >= 7) return 3'd7;
		return 3'(ones);
	endfunction

	function automatic logic [7:0] payload_mask(input logic [2:0] n);
		return (n == 3'd1) ? 8'h7F : (8'hFF >> (int'(n) + 1));
	endfunction

	function automatic logic [7:0] lead_marker(input logic [2:0] n);
		return ~(8'hFF >> int'(n));
	endfunction

	function automatic int payload_bits(input int n);
		if (n == 1) return 7;
		if (n == 7) return 32;
		return 5 * n + 1;
	endfunction

	// Each length from three to six adds five payload bits, so the length follows from the
	// position of the highest set bit.
	function automatic logic [2:0] value_len(input logic [31:0] u);
		int nb;
		nb = 0;
		for (int i = 0; i < 32; i++)
			if (u[i]) nb = i + 1;
		return (nb <= 7) ? 3'd1 : 3'((nb + 3) / 5);
	endfunction

	function automatic logic [31:0] value_of_length(input int n);
		logic [63:0] lo;
		logic [63:0] span;
		lo = (n == 1) ? 64'h0 : (64'h1 << payload_bits(n - 1));
		span = (64'h1 << payload_bits(n)) - lo;
		return 32'(lo + ({$urandom, $urandom} % span));
	endfunction

	task automatic expand_codec_word(input logic f, input logic [7:0] b, input logic [31:0] u);
		logic [2:0]  n;
		logic [7:0]  lead;
		codec_word_t w;
		if (f == FUNC_DEC) begin
			if (dec_left == 3'd0) begin
				n = lead_byte_len(b);
				dec_seq_len = n;
				dec_acc = {24'h0, b & payload_mask(n)};
				dec_left = n - 3'd1;
			end else begin
				dec_acc = {dec_acc[25:0], b[5:0]};
				dec_left = dec_left - 3'd1;
			end
			if (dec_left == 3'd0) begin
				w = '{KIND_DEC, dec_acc, 8'h00, dec_seq_len, 1'b1};
				codec_outputs_due.push_back(w);
			end
		end else begin
			n = value_len(u);
			if (n == 3'd1)
				lead = u[7:0];
			else if (n == 3'd7)
				lead = LEAD_7BYTE;
			else
				lead = (8'(u >> (6 * (int'(n) - 1))) & payload_mask(n)) | lead_marker(n);
			w = '{KIND_ENC, 32'h0, lead, n, n == 3'd1};
			codec_outputs_due.push_back(w);
			for (int k = 1; k < int'(n); k++) begin
				w = '{KIND_ENC, 32'h0,
					CONT_MARK | (8'(u >> (6 * (int'(n) - 1 - k))) & 8'h3F),
					n, k == int'(n) - 1};
				codec_outputs_due.push_back(w);
			end
		end
	endtask

	// Offers one word after a random gap and waits for the handshake; valid stays high when
	// the next word follows without a gap.
	task automatic send_word(input logic f, input logic [7:0] b, input logic [31:0] u);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.in_byte <= b;
		item_ch.in_value <= u;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		expand_codec_word(f, b, u);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(FUNC_DEC, b, $urandom);
	endtask

	task automatic send_value(input logic [31:0] u);
		send_word(FUNC_ENC, 8'($urandom), u);
	endtask

	task automatic send_utf8_sequence();
		int         n;
		logic [7:0] lead;
		n = $urandom_range(1, 7);
		case (n)
			1: lead = 8'($urandom_range(0, 127));
			7: begin
				case ($urandom_range(0, 2))
					0: lead = 8'($urandom_range(8'h80, 8'hBF));
					1: lead = LEAD_7BYTE;
					default: lead = 8'hFF;
				endcase
			end
			default: lead = lead_marker(3'(n)) | (8'($urandom) & payload_mask(3'(n)));
		endcase
		send_byte(lead);
		for (int k = 1; k < n; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_byte(8'($urandom));
			else
				send_byte(CONT_MARK | 8'($urandom_range(0, 63)));
		end
	endtask

	task automatic test_decode_extremes();
		send_byte(8'h00);
		send_byte(8'h7F);
		// A 0xFF lead opens a seven-byte sequence; all but one of its continuations carry wrong top bits.
		send_byte(8'hFF);
		send_byte(8'hC3);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'hBF);
		send_byte(8'h40);
	endtask

	task automatic test_encode_lengths();
		logic [31:0] edges[11];
		edges = '{32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'h0000_07FF, 32'h0000_FFFF,
			32'h0001_0000, 32'h001F_FFFF, 32'h03FF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF};
		foreach (edges[i]) send_value(edges[i]);
	endtask

	task automatic test_encode_mid_decode();
		send_byte(8'hE2);
		send_value(32'h0000_0041);
		send_byte(8'h82);
		send_byte(8'hAC);
	endtask

	task automatic test_output_stall();
		idle_on = 1'b0;
		hold_ask = 1'b1;
		repeat (12) send_value($urandom | 32'h8000_0000);
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int pick;
		while (items_sent < ITEM_TARGET) begin
			// Roughly a quarter of every hundred words runs with no idling on either side.
			idle_on = (items_sent % 100) < 75;
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_utf8_sequence();
			else if (pick < 85)
				send_value(value_of_length($urandom_range(1, 7)));
			else if (pick < 93)
				send_value($urandom);
			else
				send_byte(8'($urandom));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		result_ch.ready <= 1'b0;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_ask) begin
				hold_left = HOLD_CYCLES;
				hold_ask = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (codec_outputs_due.size() == 0) begin
				$error("result word with nothing expected: kind %0h byte %0h value %0h",
					result_ch.out_kind, result_ch.out_byte, result_ch.out_value);
				fail_count++;
			end else begin
				want = codec_outputs_due.pop_front();
				check_field("out_kind", 32'(want.kind), 32'(result_ch.out_kind));
				check_field("out_value", want.value, result_ch.out_value);
				check_field("out_byte", 32'(want.code), 32'(result_ch.out_byte));
				check_field("seq_len", 32'(want.len), 32'(result_ch.seq_len));
				check_field("last", 32'(want.last), 32'(result_ch.last));
			end
		end
	end

	initial begin
		fail_count = 0;
		items_sent = 0;
		idle_on = 1'b1;
		hold_ask = 1'b0;
		dec_left = 3'd0;
		dec_seq_len = 3'd0;
		dec_acc = 32'h0;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.func <= FUNC_DEC;
		item_ch.in_byte <= 8'h00;
		item_ch.in_value <= 32'h0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_decode_extremes();
		test_encode_lengths();
		test_encode_mid_decode();
		test_output_stall();
		test_random_traffic();

		item_ch.valid <= 1'b0;
		while (codec_outputs_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
sv/utf8x_pkg.sv
sv/utf8x_if.sv
sv/utf8x_front.sv
sv/utf8x_queue.sv
sv/utf8x_back.sv
sv/extended_utf8_codec.sv
sim/tb_extended_utf8_codec.sv
